@@ hdl/button_gesture_digit_counter_unit_macros.svh @@
// assertion macros for the button gesture digit counter
`ifndef BUTTON_GESTURE_DIGIT_COUNTER_UNIT_MACROS_SVH
`define BUTTON_GESTURE_DIGIT_COUNTER_UNIT_MACROS_SVH

// checked only while out of reset
`define BGDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// checked on every edge, reset included
`define BGDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bgdc_pkg.sv @@
// shared types, constants and helper functions of the button gesture digit counter
package bgdc_pkg;

    localparam int TIME_W        = 48;
    localparam int DIGIT_W       = 4;
    localparam int DIGIT_MODULUS = 10;
    localparam int CFG_W         = 24;
    localparam int REG_IDX_W     = 3;
    localparam int SEG_W         = 7;

    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [DIGIT_W-1:0]   digit_t;
    typedef logic [CFG_W-1:0]     cfg_word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [SEG_W-1:0]     seg_t;
    typedef logic [1:0]           gesture_t;

    localparam reg_idx_t REG_DEBOUNCE     = 3'd0;
    localparam reg_idx_t REG_DOUBLE_CLICK = 3'd1;
    localparam reg_idx_t REG_LONG_PRESS   = 3'd2;
    localparam reg_idx_t REG_REPEAT       = 3'd3;
    localparam reg_idx_t REG_SEG_POLARITY = 3'd4;

    localparam cfg_word_t DEBOUNCE_RST     = 24'd25000;
    localparam cfg_word_t DOUBLE_CLICK_RST = 24'd350000;
    localparam cfg_word_t LONG_PRESS_RST   = 24'd800000;
    localparam cfg_word_t REPEAT_RST       = 24'd500000;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam gesture_t GEST_CLICK        = 2'd0;
    localparam gesture_t GEST_DOUBLE_CLICK = 2'd1;
    localparam gesture_t GEST_LONG_START   = 2'd2;
    localparam gesture_t GEST_LONG_REPEAT  = 2'd3;

    typedef struct packed {
        logic  operation;
        time_t time_us;
        logic  pressed;
    } in_t;

    typedef struct packed {
        gesture_t gesture;
        digit_t   digit;
        seg_t     segments;
        logic     last;
    } out_t;

    typedef struct packed {
        cfg_word_t debounce_us;
        cfg_word_t double_click_us;
        cfg_word_t long_press_us;
        cfg_word_t repeat_period_us;
        logic      segments_active_high;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        out_t       item0;
        out_t       item1;
    } step_res_t;

    function automatic seg_t seg_of(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic digit_t digit_up(input digit_t d);
        return (d >= DIGIT_W'(DIGIT_MODULUS - 1)) ? '0 : d + DIGIT_W'(1);
    endfunction

    function automatic digit_t digit_down(input digit_t d);
        return (d == '0) ? DIGIT_W'(DIGIT_MODULUS - 1) : d - DIGIT_W'(1);
    endfunction

    function automatic out_t make_result(input gesture_t g, input digit_t d,
                                         input logic active_high);
        out_t r;
        r.gesture  = g;
        r.digit    = d;
        r.segments = active_high ? seg_of(d) : ~seg_of(d);
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/button_gesture_digit_counter_unit.sv @@
// top level of the button gesture digit counter: config registers, input and result buffers
// an accepted item is held in the input register and evaluated once the result buffer can
// take its results; its first result is then offered from the result buffer
// throughput: one item per cycle while each yields at most one result and m_ready stays high;
// an item yielding two stalls input until the single result port drains the two-entry result buffer
// reset: synchronous active-low aresetn clears gesture state, digit and buffers, loads config defaults
module button_gesture_digit_counter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bgdc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [bgdc_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bgdc_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bgdc_pkg::out_t              m_data
);
    import bgdc_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg, in_valid_next;
    in_t        in_data_reg;
    logic [1:0] out_cnt_reg, out_cnt_next;
    out_t       slot0_reg, slot0_next;
    out_t       slot1_reg, slot1_next;
    logic       out_free, step_en;
    step_res_t  step_res;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_us          <= DEBOUNCE_RST;
            cfg_reg.double_click_us      <= DOUBLE_CLICK_RST;
            cfg_reg.long_press_us        <= LONG_PRESS_RST;
            cfg_reg.repeat_period_us     <= REPEAT_RST;
            cfg_reg.segments_active_high <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE:     cfg_reg.debounce_us          <= cfg_wr_data;
                REG_DOUBLE_CLICK: cfg_reg.double_click_us      <= cfg_wr_data;
                REG_LONG_PRESS:   cfg_reg.long_press_us        <= cfg_wr_data;
                REG_REPEAT:       cfg_reg.repeat_period_us     <= cfg_wr_data;
                REG_SEG_POLARITY: cfg_reg.segments_active_high <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign out_free = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_ready);
    assign step_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step_en;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (step_en) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    bgdc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (in_data_reg),
        .step_en (step_en),
        .res     (step_res)
    );

    // two-entry result buffer
    always_comb begin
        out_cnt_next = out_cnt_reg;
        slot0_next   = slot0_reg;
        slot1_next   = slot1_reg;
        if (m_valid && m_ready) begin
            if (out_cnt_reg == 2'd2) begin
                slot0_next   = slot1_reg;
                out_cnt_next = 2'd1;
            end else begin
                out_cnt_next = 2'd0;
            end
        end
        if (step_en) begin
            out_cnt_next = step_res.count;
            slot0_next   = step_res.item0;
            slot1_next   = step_res.item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= 2'd0;
        end else begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_valid = (out_cnt_reg != 2'd0);
    assign m_data  = slot0_reg;

endmodule

@@ hdl/bgdc_core.sv @@
// gesture state and single-pass step logic: debounce, click, double click, long press
module bgdc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bgdc_pkg::cfg_t        cfg,
    input  bgdc_pkg::in_t         item,
    input  logic                  step_en,
    output bgdc_pkg::step_res_t   res
);
    import bgdc_pkg::*;

    logic   button_down_reg, button_down_next;
    logic   edge_seen_reg, edge_seen_next;
    time_t  last_edge_time_reg, last_edge_time_next;
    time_t  press_time_reg, press_time_next;
    logic   repeating_reg, repeating_next;
    time_t  next_repeat_time_reg, next_repeat_time_next;
    logic   click_armed_reg, click_armed_next;
    time_t  click_time_reg, click_time_next;
    digit_t digit_val_reg, digit_val_next;

    time_t  dt_edge, dt_press, dt_repeat, dt_click, dt_prev_click;
    logic   edge_early, accept_edge, proceed;
    logic [1:0] cnt;
    out_t   slot [2];

    always_comb begin
        button_down_next      = button_down_reg;
        edge_seen_next        = edge_seen_reg;
        last_edge_time_next   = last_edge_time_reg;
        press_time_next       = press_time_reg;
        repeating_next        = repeating_reg;
        next_repeat_time_next = next_repeat_time_reg;
        click_armed_next      = click_armed_reg;
        click_time_next       = click_time_reg;
        digit_val_next        = digit_val_reg;
        cnt                   = 2'd0;
        slot[0]               = '0;
        slot[1]               = '0;

        dt_edge       = item.time_us - last_edge_time_reg;
        dt_prev_click = item.time_us - click_time_reg;
        edge_early    = edge_seen_reg && (dt_edge < time_t'(cfg.debounce_us));
        accept_edge   = (item.operation == OP_EDGE) && !edge_early &&
                        (item.pressed != button_down_reg);
        proceed       = (item.operation == OP_TICK) || accept_edge;

        // edge handling
        if (accept_edge) begin
            edge_seen_next      = 1'b1;
            last_edge_time_next = item.time_us;
            button_down_next    = item.pressed;
            if (item.pressed) begin
                press_time_next = item.time_us;
                repeating_next  = 1'b0;
            end else if (repeating_reg) begin
                repeating_next = 1'b0;
            end else if (click_armed_reg &&
                         (dt_prev_click <= time_t'(cfg.double_click_us))) begin
                click_armed_next   = 1'b0;
                digit_val_next     = digit_down(digit_val_next);
                slot[cnt[0]]       = make_result(GEST_DOUBLE_CLICK, digit_val_next,
                                                 cfg.segments_active_high);
                cnt                = cnt + 2'd1;
            end else begin
                click_armed_next   = 1'b1;
                click_time_next    = item.time_us;
            end
        end

        dt_press  = item.time_us - press_time_next;
        dt_repeat = item.time_us - next_repeat_time_reg;
        dt_click  = item.time_us - click_time_next;

        // deadline checks
        if (proceed) begin
            if (button_down_next && !repeating_next &&
                (dt_press >= time_t'(cfg.long_press_us))) begin
                if (click_armed_next) begin
                    click_armed_next   = 1'b0;
                    digit_val_next     = digit_up(digit_val_next);
                    slot[cnt[0]]       = make_result(GEST_CLICK, digit_val_next,
                                                     cfg.segments_active_high);
                    cnt                = cnt + 2'd1;
                end
                repeating_next        = 1'b1;
                next_repeat_time_next = item.time_us + time_t'(cfg.repeat_period_us);
                digit_val_next        = digit_up(digit_val_next);
                slot[cnt[0]]          = make_result(GEST_LONG_START, digit_val_next,
                                                    cfg.segments_active_high);
                cnt                   = cnt + 2'd1;
            end else if (button_down_next && repeating_next && !dt_repeat[TIME_W-1]) begin
                next_repeat_time_next = next_repeat_time_reg +
                                        time_t'(cfg.repeat_period_us);
                digit_val_next        = digit_up(digit_val_next);
                slot[cnt[0]]          = make_result(GEST_LONG_REPEAT, digit_val_next,
                                                    cfg.segments_active_high);
                cnt                   = cnt + 2'd1;
            end

            if (click_armed_next && (cnt < 2'd2) &&
                (dt_click > time_t'(cfg.double_click_us))) begin
                click_armed_next   = 1'b0;
                digit_val_next     = digit_up(digit_val_next);
                slot[cnt[0]]       = make_result(GEST_CLICK, digit_val_next,
                                                 cfg.segments_active_high);
                cnt                = cnt + 2'd1;
            end
        end

        res.count      = cnt;
        res.item0      = slot[0];
        res.item0.last = (cnt == 2'd1);
        res.item1      = slot[1];
        res.item1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_down_reg      <= 1'b0;
            edge_seen_reg        <= 1'b0;
            last_edge_time_reg   <= '0;
            press_time_reg       <= '0;
            repeating_reg        <= 1'b0;
            next_repeat_time_reg <= '0;
            click_armed_reg      <= 1'b0;
            click_time_reg       <= '0;
            digit_val_reg        <= '0;
        end else if (step_en) begin
            button_down_reg      <= button_down_next;
            edge_seen_reg        <= edge_seen_next;
            last_edge_time_reg   <= last_edge_time_next;
            press_time_reg       <= press_time_next;
            repeating_reg        <= repeating_next;
            next_repeat_time_reg <= next_repeat_time_next;
            click_armed_reg      <= click_armed_next;
            click_time_reg       <= click_time_next;
            digit_val_reg        <= digit_val_next;
        end
    end

endmodule

@@ hdl/bgdc_checker.sv @@
// port-level checker for the button gesture digit counter and its bind
`include "button_gesture_digit_counter_unit_macros.svh"

module bgdc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input bgdc_pkg::out_t              m_data
);
    import bgdc_pkg::*;

    // a stalled result holds
    `BGDC_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped or changed while stalled")

    // digit stays in range
    `BGDC_ASSERT(a_digit_range, aclk, aresetn, m_valid |-> m_data.digit < DIGIT_W'(DIGIT_MODULUS), "digit out of range")

    // second result of an item follows right after the first
    `BGDC_ASSERT(a_second_follows, aclk, aresetn, m_valid && m_ready && !m_data.last |=> m_valid, "second result of an item missing")

    // reset empties the result side
    `BGDC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result offered after reset")

endmodule

bind button_gesture_digit_counter_unit bgdc_checker u_bgdc_checker (.*);

@@ tb/button_gesture_digit_counter_unit_test.sv @@
// testbench for the button gesture digit counter: directed and random button traffic checked
`timescale 1ns / 1ps

module button_gesture_digit_counter_unit_test;
    import bgdc_pkg::*;

    class gesture_scoreboard;
        cfg_word_t debounce_us;
        cfg_word_t double_click_us;
        cfg_word_t long_press_us;
        cfg_word_t repeat_period_us;
        bit        lit_high;
        bit        button_down;
        bit        edge_seen;
        bit        repeating;
        bit        click_armed;
        time_t     last_edge_time;
        time_t     press_time;
        time_t     next_repeat_time;
        time_t     click_time;
        digit_t    digit_now;
        seg_t      seg_lit [10];
        out_t      expected_gestures [$];
        int        errors;

        function new();
            seg_lit = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
            debounce_us      = DEBOUNCE_RST;
            double_click_us  = DOUBLE_CLICK_RST;
            long_press_us    = LONG_PRESS_RST;
            repeat_period_us = REPEAT_RST;
            lit_high         = 1'b1;
            button_down      = 1'b0;
            edge_seen        = 1'b0;
            repeating        = 1'b0;
            click_armed      = 1'b0;
            last_edge_time   = '0;
            press_time       = '0;
            next_repeat_time = '0;
            click_time       = '0;
            digit_now        = '0;
            errors           = 0;
        endfunction

        function void set_reg(reg_idx_t idx, cfg_word_t value);
            case (idx)
                REG_DEBOUNCE:     debounce_us = value;
                REG_DOUBLE_CLICK: double_click_us = value;
                REG_LONG_PRESS:   long_press_us = value;
                REG_REPEAT:       repeat_period_us = value;
                REG_SEG_POLARITY: lit_high = value[0];
                default: ;
            endcase
        endfunction

        function out_t step_digit(gesture_t g, bit up);
            out_t r;
            if (up) begin
                digit_now = (digit_now == digit_t'(DIGIT_MODULUS - 1)) ? '0 : digit_now + 1'b1;
            end else begin
                digit_now = (digit_now == '0) ? digit_t'(DIGIT_MODULUS - 1) : digit_now - 1'b1;
            end
            r.gesture  = g;
            r.digit    = digit_now;
            r.segments = lit_high ? seg_lit[digit_now] : ~seg_lit[digit_now];
            r.last     = 1'b0;
            return r;
        endfunction

        // returns 0 when the edge is dropped by debounce or level check
        function bit take_button_item(in_t x);
            time_t t;
            time_t diff;
            out_t  made [$];
            out_t  r;
            t = x.time_us;
            if (x.operation == OP_EDGE) begin
                diff = t - last_edge_time;
                if ((edge_seen && diff < time_t'(debounce_us)) || x.pressed == button_down)
                    return 1'b0;
                edge_seen      = 1'b1;
                last_edge_time = t;
                button_down    = x.pressed;
                if (x.pressed) begin
                    press_time = t;
                    repeating  = 1'b0;
                end else if (repeating) begin
                    repeating = 1'b0;
                end else begin
                    diff = t - click_time;
                    if (click_armed && diff <= time_t'(double_click_us)) begin
                        click_armed = 1'b0;
                        made.push_back(step_digit(GEST_DOUBLE_CLICK, 1'b0));
                    end else begin
                        click_armed = 1'b1;
                        click_time  = t;
                    end
                end
            end
            diff = t - press_time;
            if (button_down && !repeating && diff >= time_t'(long_press_us)) begin
                if (click_armed) begin
                    click_armed = 1'b0;
                    made.push_back(step_digit(GEST_CLICK, 1'b1));
                end
                repeating        = 1'b1;
                next_repeat_time = t + time_t'(repeat_period_us);
                made.push_back(step_digit(GEST_LONG_START, 1'b1));
            end else begin
                diff = t - next_repeat_time;
                if (button_down && repeating && !diff[TIME_W-1]) begin
                    next_repeat_time = next_repeat_time + time_t'(repeat_period_us);
                    made.push_back(step_digit(GEST_LONG_REPEAT, 1'b1));
                end
            end
            diff = t - click_time;
            if (click_armed && made.size() < 2 && diff > time_t'(double_click_us)) begin
                click_armed = 1'b0;
                made.push_back(step_digit(GEST_CLICK, 1'b1));
            end
            foreach (made[i]) begin
                r      = made[i];
                r.last = (i == made.size() - 1);
                expected_gestures.push_back(r);
            end
            return 1'b1;
        endfunction

        function void check_gesture(out_t got);
            out_t want;
            if (expected_gestures.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = expected_gestures.pop_front();
            if (got.gesture !== want.gesture) begin
                errors++;
                $display("%0t gesture: expected %0d actual %0d", $time, want.gesture,
                         got.gesture);
            end
            if (got.digit !== want.digit) begin
                errors++;
                $display("%0t digit: expected %0d actual %0d", $time, want.digit, got.digit);
            end
            if (got.segments !== want.segments) begin
                errors++;
                $display("%0t segments: expected %h actual %h", $time, want.segments,
                         got.segments);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t last: expected %0d actual %0d", $time, want.last, got.last);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    reg_idx_t  cfg_index = '0;
    cfg_word_t cfg_wr_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_t       s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_t      m_data;

    gesture_scoreboard sb = new();

    bit    offering = 1'b0;
    int    burst_left = 0;
    int    counted_items = 0;
    time_t now = '0;
    bit    hold_req = 1'b0;
    int    hold_left = 0;
    int    stall_mode = 0;
    int    stall_run = 0;
    int    cycle_count = 0;

    button_gesture_digit_counter_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check every transfer, stall on a pattern of its own
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_gesture(m_data);
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 200);
        end
        stall_run--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ~m_ready;
                2:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic in_t make_item(logic op, time_t t, logic p);
        in_t r;
        r.operation = op;
        r.time_us   = t;
        r.pressed   = p;
        return r;
    endfunction

    task automatic send_item(in_t item);
        if (burst_left == 0) begin
            if (offering) begin
                s_valid  <= 1'b0;
                offering = 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        s_valid  <= 1'b1;
        s_data   <= item;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (sb.take_button_item(item))
            counted_items++;
    endtask

    task automatic idle_sender();
        if (offering) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
        end
        burst_left = 0;
    endtask

    task automatic wait_drained();
        idle_sender();
        while (sb.expected_gestures.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, cfg_word_t value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_config(cfg_word_t deb, cfg_word_t dc, cfg_word_t lp,
                                cfg_word_t rp, logic pol);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_DOUBLE_CLICK, dc);
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_REPEAT, rp);
        write_reg(REG_SEG_POLARITY, cfg_word_t'(pol));
        cfg_wr_en <= 1'b0;
    endtask

    // time steps clustered around the configured thresholds, with rare wrapping jumps
    function automatic time_t any_gap();
        longint v;
        case ($urandom_range(0, 15))
            0, 1:   v = $urandom_range(0, 3);
            2, 3:   v = sb.debounce_us;
            4, 5:   v = sb.double_click_us;
            6, 7:   v = sb.long_press_us;
            8, 9:   v = sb.repeat_period_us;
            10, 11: v = $urandom_range(0, sb.long_press_us);
            12, 13: v = $urandom_range(0, sb.repeat_period_us);
            14:     return time_t'({$urandom, $urandom});
            default: v = $urandom_range(0, 2 * sb.double_click_us);
        endcase
        v = v + longint'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        return time_t'(v);
    endfunction

    function automatic time_t edge_gap();
        time_t g;
        g = any_gap();
        if (g < time_t'(sb.debounce_us))
            g = time_t'(sb.debounce_us) + time_t'($urandom_range(0, 2));
        return g;
    endfunction

    task automatic edge_after(logic p, time_t d);
        now = now + d;
        send_item(make_item(OP_EDGE, now, p));
    endtask

    task automatic tick_after(time_t d);
        now = now + d;
        send_item(make_item(OP_TICK, now, 1'($urandom_range(0, 1))));
    endtask

    task automatic gesture_sequence();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                edge_after(1'b1, edge_gap());
                edge_after(1'b0, edge_gap());
                tick_after(any_gap());
            end
            2, 3: begin
                edge_after(1'b1, edge_gap());
                edge_after(1'b0, edge_gap());
                edge_after(1'b1, edge_gap());
                edge_after(1'b0, edge_gap());
                tick_after(any_gap());
            end
            4, 5: begin
                edge_after(1'b1, edge_gap());
                repeat ($urandom_range(1, 6)) tick_after(any_gap());
                edge_after(1'b0, edge_gap());
            end
            6: begin
                edge_after(1'b0, edge_gap());
                edge_after(1'b1, edge_gap());
                tick_after(any_gap());
                tick_after(any_gap());
            end
            7, 8: begin
                repeat ($urandom_range(1, 6)) begin
                    now = now + any_gap();
                    send_item(make_item(1'($urandom_range(0, 1)), now,
                                        1'($urandom_range(0, 1))));
                end
            end
            default: begin
                now = time_t'({$urandom, $urandom});
                tick_after('0);
                edge_after(1'($urandom_range(0, 1)), edge_gap());
            end
        endcase
    endtask

    task automatic run_phase(int target);
        int stop_at;
        stop_at = counted_items + target;
        while (counted_items < stop_at)
            gesture_sequence();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset settings
        send_item(make_item(OP_TICK, 48'd0, 1'b1));
        send_item(make_item(OP_EDGE, 48'd0, 1'b0));
        send_item(make_item(OP_EDGE, 48'd0, 1'b1));
        send_item(make_item(OP_EDGE, 48'd100000, 1'b1));
        send_item(make_item(OP_EDGE, 48'd10000, 1'b0));
        send_item(make_item(OP_EDGE, 48'd100000, 1'b0));
        send_item(make_item(OP_TICK, 48'd450000, 1'b0));
        send_item(make_item(OP_TICK, 48'd450001, 1'b0));
        send_item(make_item(OP_EDGE, 48'd500000, 1'b1));
        send_item(make_item(OP_EDGE, 48'd600000, 1'b0));
        send_item(make_item(OP_EDGE, 48'd700000, 1'b1));
        send_item(make_item(OP_EDGE, 48'd800000, 1'b0));
        send_item(make_item(OP_EDGE, 48'd1000000, 1'b1));
        send_item(make_item(OP_TICK, 48'd1800000, 1'b0));
        send_item(make_item(OP_TICK, 48'd2300000, 1'b0));
        send_item(make_item(OP_TICK, 48'd5000000, 1'b0));
        send_item(make_item(OP_TICK, 48'd5000001, 1'b0));
        send_item(make_item(OP_EDGE, 48'd5100000, 1'b0));
        send_item(make_item(OP_EDGE, 48'd6000000, 1'b1));
        send_item(make_item(OP_EDGE, 48'd7000000, 1'b0));
        send_item(make_item(OP_EDGE, 48'd7100000, 1'b1));
        send_item(make_item(OP_TICK, 48'd7900000, 1'b0));
        send_item(make_item(OP_EDGE, 48'd8000000, 1'b0));
        send_item(make_item(OP_EDGE, 48'hFFFF_FFFF_FFFF, 1'b1));
        send_item(make_item(OP_TICK, 48'd799999, 1'b0));
        send_item(make_item(OP_EDGE, 48'd900000, 1'b0));
        now = 48'd900000;
        run_phase(130);
        wait_drained();

        apply_config('0, '0, 24'd1, 24'd1, 1'b0);
        run_phase(150);
        wait_drained();

        apply_config('1, '1, '1, '1, 1'b1);
        run_phase(150);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5)
                apply_config(cfg_word_t'($urandom_range(0, 24'hFFFFFF)),
                             cfg_word_t'($urandom_range(0, 24'hFFFFFF)),
                             cfg_word_t'($urandom_range(1, 24'hFFFFFF)),
                             cfg_word_t'($urandom_range(1, 24'hFFFFFF)),
                             1'($urandom_range(0, 1)));
            else
                apply_config(cfg_word_t'($urandom_range(0, 50)),
                             cfg_word_t'($urandom_range(0, 300)),
                             cfg_word_t'($urandom_range(1, 400)),
                             cfg_word_t'($urandom_range(1, 150)),
                             1'($urandom_range(0, 1)));
            if (ph == 1)
                hold_req = 1'b1;
            run_phase(150);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
